// ===== hw/rtl/record_frame_checker_macros.svh =====
// assertion helpers for the record frame checker
`ifndef RECORD_FRAME_CHECKER_MACROS_SVH
`define RECORD_FRAME_CHECKER_MACROS_SVH

// checked only out of reset
`define RFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define RFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/rfc_pkg.sv =====
package rfc_pkg;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [24:0] record_size;
  } out_beat_t;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TRUNC_HDR   = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION = 3'd3;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd4;
  localparam logic [2:0] ST_TRUNC_PAY   = 3'd5;
  localparam logic [2:0] ST_NO_CRC      = 3'd6;
  localparam logic [2:0] ST_CRC_BAD     = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_VERSION = 2'd1;
  localparam logic [1:0] CFG_MAX_PAY = 2'd2;

  // reset values of the configuration registers
  localparam logic [31:0] MAGIC_RST   = 32'd0;
  localparam logic [15:0] VERSION_RST = 16'd1;
  localparam logic [23:0] MAX_PAY_RST = 24'd65536;

  // record layout
  localparam logic [23:0] MAGIC_END    = 24'd4;
  localparam logic [23:0] VERSION_END  = 24'd6;
  localparam logic [23:0] HDR_BYTES    = 24'd10;
  localparam logic [23:0] CRC_BYTES    = 24'd4;
  localparam logic [24:0] REC_OVERHEAD = 25'd14;

  // reflected ieee crc-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

endpackage

// ===== hw/rtl/record_frame_checker.sv =====
// channel   | dir | handshake         | beat
// ----------+-----+-------------------+-----------------------------------------
// in        | in  | in_valid/in_stall | in_data: data_byte, end_of_stream
// out       | out | out_valid/out_stall | out_data: is_status, payload_byte,
//           |     |                   |   status, record_size
// cfg       | in  | cfg_we            | cfg_index, cfg_data (magic, version, max)
//
// one beat per cycle unless in_stall holds it: header parse, crc byte update and
// checks sit between the frame state registers and the single output register
// a result shows on out in the cycle after its input beat is taken
// in_stall rises only while the output register is full and out_stall is high
// synchronous active low reset: header phase, crc all ones, output empty

`include "record_frame_checker_macros.svh"

module record_frame_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rfc_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rfc_pkg::out_beat_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [2:0] {
    PH_HDR          = 3'd0,
    PH_HDR_BADMAGIC = 3'd1,
    PH_HDR_BADVER   = 3'd2,
    PH_PAY          = 3'd3,
    PH_CRC          = 3'd4,
    PH_DISCARD      = 3'd5
  } phase_t;

  // configuration
  logic [31:0] magic_r;
  logic [15:0] version_r;
  logic [23:0] max_pay_r;

  // frame state
  phase_t      phase_r, phase_nxt;
  logic [23:0] field_count_r, field_count_nxt;
  logic [31:0] field_shift_r, field_shift_nxt;
  logic [23:0] length_held_r, length_held_nxt;
  logic [31:0] running_crc_r, running_crc_nxt;

  // output register
  logic               out_valid_r;
  rfc_pkg::out_beat_t out_data_r;

  logic               accept;
  logic               res_vld;
  rfc_pkg::out_beat_t res;
  logic [31:0]        crc_upd;
  logic [31:0]        sh;
  logic [23:0]        cnt_inc;
  logic               in_header;

  // the output register frees itself whenever the far side takes its beat
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rfc_crc_byte u_crc (
    .crc_in  (running_crc_r),
    .data_in (in_data.data_byte),
    .crc_out (crc_upd)
  );

  // incoming byte goes in at the top, so four bytes leave a little-endian word
  assign sh        = {in_data.data_byte, field_shift_r[31:8]};
  assign cnt_inc   = field_count_r + 24'd1;
  assign in_header = (phase_r == PH_HDR) || (phase_r == PH_HDR_BADMAGIC) ||
                     (phase_r == PH_HDR_BADVER);

  always_comb begin
    phase_nxt       = phase_r;
    field_count_nxt = field_count_r;
    field_shift_nxt = field_shift_r;
    length_held_nxt = length_held_r;
    running_crc_nxt = running_crc_r;
    res_vld         = 1'b0;
    res             = '0;

    if (in_data.end_of_stream) begin
      // stream ended: report what was cut short, then back to a fresh header
      res.is_status = 1'b1;
      if (in_header) begin
        res_vld    = (field_count_r != 24'd0) || (phase_r != PH_HDR);
        res.status = rfc_pkg::ST_TRUNC_HDR;
      end else if (phase_r == PH_PAY) begin
        res_vld    = 1'b1;
        res.status = rfc_pkg::ST_TRUNC_PAY;
      end else if (phase_r == PH_CRC) begin
        res_vld    = 1'b1;
        res.status = rfc_pkg::ST_NO_CRC;
      end
      phase_nxt       = PH_HDR;
      field_count_nxt = '0;
      field_shift_nxt = '0;
      length_held_nxt = '0;
      running_crc_nxt = rfc_pkg::CRC_INIT;
    end else begin
      case (phase_r)
        PH_HDR, PH_HDR_BADMAGIC, PH_HDR_BADVER: begin
          field_count_nxt = cnt_inc;
          field_shift_nxt = sh;
          if (cnt_inc == rfc_pkg::MAGIC_END) begin
            if ((phase_r == PH_HDR) && (sh != magic_r)) begin
              phase_nxt = PH_HDR_BADMAGIC;
            end
            field_shift_nxt = '0;
          end else if (cnt_inc == rfc_pkg::VERSION_END) begin
            if ((phase_r == PH_HDR) && (sh[31:16] != version_r)) begin
              phase_nxt = PH_HDR_BADVER;
            end
            field_shift_nxt = '0;
          end else if (cnt_inc >= rfc_pkg::HDR_BYTES) begin
            // whole header in: errors go out in priority order
            field_shift_nxt = '0;
            field_count_nxt = '0;
            res.is_status   = 1'b1;
            if (phase_r == PH_HDR_BADMAGIC) begin
              res_vld    = 1'b1;
              res.status = rfc_pkg::ST_BAD_MAGIC;
              phase_nxt  = PH_DISCARD;
            end else if (phase_r == PH_HDR_BADVER) begin
              res_vld    = 1'b1;
              res.status = rfc_pkg::ST_BAD_VERSION;
              phase_nxt  = PH_DISCARD;
            end else if ((sh == 32'd0) || (sh > {8'd0, max_pay_r})) begin
              res_vld    = 1'b1;
              res.status = rfc_pkg::ST_BAD_LENGTH;
              phase_nxt  = PH_DISCARD;
            end else begin
              length_held_nxt = sh[23:0];
              running_crc_nxt = rfc_pkg::CRC_INIT;
              phase_nxt       = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          // pass the byte through and fold it into the crc
          running_crc_nxt  = crc_upd;
          field_count_nxt  = cnt_inc;
          res_vld          = 1'b1;
          res.payload_byte = in_data.data_byte;
          if (cnt_inc >= length_held_r) begin
            phase_nxt       = PH_CRC;
            field_count_nxt = '0;
            field_shift_nxt = '0;
          end
        end
        PH_CRC: begin
          field_shift_nxt = sh;
          field_count_nxt = cnt_inc;
          if (cnt_inc >= rfc_pkg::CRC_BYTES) begin
            res_vld       = 1'b1;
            res.is_status = 1'b1;
            field_count_nxt = '0;
            field_shift_nxt = '0;
            if (sh == ~running_crc_r) begin
              res.status      = rfc_pkg::ST_OK;
              res.record_size = {1'b0, length_held_r} + rfc_pkg::REC_OVERHEAD;
              phase_nxt       = PH_HDR;
              length_held_nxt = '0;
              running_crc_nxt = rfc_pkg::CRC_INIT;
            end else begin
              res.status = rfc_pkg::ST_CRC_BAD;
              phase_nxt  = PH_DISCARD;
            end
          end
        end
        default: begin
          // discard until end of stream
          phase_nxt = PH_DISCARD;
        end
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= rfc_pkg::MAGIC_RST;
      version_r <= rfc_pkg::VERSION_RST;
      max_pay_r <= rfc_pkg::MAX_PAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rfc_pkg::CFG_MAGIC:   magic_r   <= cfg_data;
        rfc_pkg::CFG_VERSION: version_r <= cfg_data[15:0];
        rfc_pkg::CFG_MAX_PAY: max_pay_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // frame state and output register; payload loaded only with a new result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HDR;
      field_count_r <= '0;
      field_shift_r <= '0;
      length_held_r <= '0;
      running_crc_r <= rfc_pkg::CRC_INIT;
      out_valid_r   <= 1'b0;
      out_data_r    <= '0;
    end else begin
      if (accept) begin
        phase_r       <= phase_nxt;
        field_count_r <= field_count_nxt;
        field_shift_r <= field_shift_nxt;
        length_held_r <= length_held_nxt;
        running_crc_r <= running_crc_nxt;
      end
      if (accept && res_vld) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `RFC_ASSERT(a_pay_byte_out,
    accept && !in_data.end_of_stream && (phase_r == PH_PAY) |=>
    out_valid_r && !out_data_r.is_status,
    "payload byte did not produce a byte result")

  `RFC_ASSERT(a_ok_size,
    out_valid_r && out_data_r.is_status && (out_data_r.status == rfc_pkg::ST_OK) |->
    out_data_r.record_size > rfc_pkg::REC_OVERHEAD,
    "ok status with impossible record size")

  `RFC_ASSERT(a_eos_restart,
    accept && in_data.end_of_stream |=>
    (phase_r == PH_HDR) && (field_count_r == 24'd0) && (running_crc_r == rfc_pkg::CRC_INIT),
    "end of stream did not restart at a header")

  `RFC_ASSERT(a_hdr_count,
    (phase_r == PH_HDR) || (phase_r == PH_HDR_BADMAGIC) || (phase_r == PH_HDR_BADVER) |->
    field_count_r < rfc_pkg::HDR_BYTES,
    "header byte count ran past the header")

  `RFC_ASSERT_ALWAYS(a_stall_needs_full,
    in_stall |-> out_valid_r,
    "input stalled with an empty output register")

endmodule

// ===== hw/rtl/rfc_crc_byte.sv =====
module rfc_crc_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);

  // one byte of the reflected crc, bit at a time lsb first
  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ rfc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// ===== tb/rfc_tb_pkg.sv =====
package rfc_tb_pkg;
  import rfc_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_HDR_MAGIC_BAD,
    PH_HDR_VERSION_BAD,
    PH_PAYLOAD,
    PH_CHECKSUM,
    PH_DISCARD
  } frame_phase_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] d);
    logic [31:0] c;
    c = crc ^ {24'd0, d};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  class record_scoreboard;
    logic [31:0]  magic;
    logic [15:0]  version;
    logic [23:0]  max_pay;
    frame_phase_t phase;
    logic [23:0]  count;
    logic [31:0]  shift;
    logic [23:0]  len_held;
    logic [31:0]  crc;
    out_beat_t    results_due[$];
    int           errors;

    function new();
      magic   = MAGIC_RST;
      version = VERSION_RST;
      max_pay = MAX_PAY_RST;
      errors  = 0;
      restart();
    endfunction

    function void restart();
      phase    = PH_HEADER;
      count    = '0;
      shift    = '0;
      len_held = '0;
      crc      = CRC_INIT;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_MAGIC:   magic   = val;
        CFG_VERSION: version = val[15:0];
        CFG_MAX_PAY: max_pay = val[23:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // works out the result of one accepted input beat
    function void note_beat(in_beat_t b);
      out_beat_t   r;
      logic [31:0] len;
      bit          emit;
      r    = '0;
      emit = 1'b0;
      r.is_status = 1'b1;
      if (b.end_of_stream) begin
        case (phase)
          PH_HEADER: begin
            if (count != 0) begin
              emit = 1'b1;
              r.status = ST_TRUNC_HDR;
            end
          end
          PH_HDR_MAGIC_BAD, PH_HDR_VERSION_BAD: begin
            emit = 1'b1;
            r.status = ST_TRUNC_HDR;
          end
          PH_PAYLOAD: begin
            emit = 1'b1;
            r.status = ST_TRUNC_PAY;
          end
          PH_CHECKSUM: begin
            emit = 1'b1;
            r.status = ST_NO_CRC;
          end
          default: ;
        endcase
        restart();
      end else begin
        case (phase)
          PH_HEADER, PH_HDR_MAGIC_BAD, PH_HDR_VERSION_BAD: begin
            shift = {b.data_byte, shift[31:8]};
            count = count + 24'd1;
            if (count == MAGIC_END) begin
              if (phase == PH_HEADER && shift != magic) phase = PH_HDR_MAGIC_BAD;
              shift = '0;
            end else if (count == VERSION_END) begin
              if (phase == PH_HEADER && shift[31:16] != version) phase = PH_HDR_VERSION_BAD;
              shift = '0;
            end else if (count >= HDR_BYTES) begin
              len   = shift;
              shift = '0;
              count = '0;
              emit  = 1'b1;
              if (phase == PH_HDR_MAGIC_BAD) begin
                r.status = ST_BAD_MAGIC;
              end else if (phase == PH_HDR_VERSION_BAD) begin
                r.status = ST_BAD_VERSION;
              end else if (len == 0 || len > {8'd0, max_pay}) begin
                r.status = ST_BAD_LENGTH;
              end else begin
                emit     = 1'b0;
                len_held = len[23:0];
                crc      = CRC_INIT;
                phase    = PH_PAYLOAD;
              end
              if (emit) phase = PH_DISCARD;
            end
          end
          PH_PAYLOAD: begin
            crc   = crc32_step(crc, b.data_byte);
            count = count + 24'd1;
            if (count >= len_held) begin
              phase = PH_CHECKSUM;
              count = '0;
              shift = '0;
            end
            emit = 1'b1;
            r.is_status    = 1'b0;
            r.payload_byte = b.data_byte;
          end
          PH_CHECKSUM: begin
            shift = {b.data_byte, shift[31:8]};
            count = count + 24'd1;
            if (count >= CRC_BYTES) begin
              emit = 1'b1;
              if (shift == ~crc) begin
                r.status      = ST_OK;
                r.record_size = REC_OVERHEAD + {1'b0, len_held};
                restart();
              end else begin
                r.status = ST_CRC_BAD;
                phase    = PH_DISCARD;
                count    = '0;
                shift    = '0;
              end
            end
          end
          default: phase = PH_DISCARD;
        endcase
      end
      if (emit) results_due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (results_due.size() == 0) begin
        report($sformatf("result beat %h with nothing due", got));
        return;
      end
      want = results_due.pop_front();
      if (got.is_status != want.is_status)
        report($sformatf("is_status got %0d want %0d", got.is_status, want.is_status));
      if (got.payload_byte != want.payload_byte)
        report($sformatf("payload_byte got %h want %h", got.payload_byte, want.payload_byte));
      if (got.status != want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.record_size != want.record_size)
        report($sformatf("record_size got %0d want %0d", got.record_size, want.record_size));
    endtask

    task flag_leftover();
      foreach (results_due[i]) report($sformatf("result %h never arrived", results_due[i]));
      results_due.delete();
    endtask
  endclass

endpackage

// ===== tb/record_frame_checker_test.sv =====
module record_frame_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfc_pkg::*;
  import rfc_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  record_scoreboard sb;
  int beats_sent = 0;   // beats that the parser really looks at
  bit calm = 1'b0;      // no gaps and no stalls while set

  record_frame_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // hard stop if the handshake hangs
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // sampled at the edge, before this edge's updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_beat(in_data);
      if (out_valid && !out_stall) sb.check_beat(out_data);
    end
  end

  function automatic int draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 6);
  endfunction

  // receiver side: random stall before every result beat
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = draw_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one input beat, held until taken; valid stays up across back-to-back beats
  task automatic push_beat(input logic [7:0] d, input bit eos, input bit counted);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: d, end_of_stream: eos};
    do @(posedge clk); while (in_stall);
    if (counted) beats_sent++;
  endtask

  // register write, only while the block is quiet
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // stop sending and wait for every due result
  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // header, payload and crc if pay_n > 0; 0 <= cut < size ends the stream after cut bytes
  task automatic send_record(input logic [31:0] mg, input logic [15:0] vr,
                             input logic [31:0] ln, input int pay_n, input int fill,
                             input int cut, input bit spoil);
    logic [7:0]  rec[$];
    logic [31:0] c;
    logic [7:0]  d;
    for (int i = 0; i < 4; i++) rec.push_back(mg[8*i +: 8]);
    for (int i = 0; i < 2; i++) rec.push_back(vr[8*i +: 8]);
    for (int i = 0; i < 4; i++) rec.push_back(ln[8*i +: 8]);
    if (pay_n > 0) begin
      c = CRC_INIT;
      for (int i = 0; i < pay_n; i++) begin
        d = (fill < 0) ? 8'($urandom) : fill[7:0];
        rec.push_back(d);
        c = crc32_step(c, d);
      end
      c = ~c;
      if (spoil) c = c ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) rec.push_back(c[8*i +: 8]);
    end
    if (cut < 0 || cut >= rec.size()) begin
      foreach (rec[i]) push_beat(rec[i], 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < cut; i++) push_beat(rec[i], 1'b0, 1'b1);
      push_beat(8'($urandom), 1'b1, 1'b1);
    end
  endtask

  // bytes the block throws away, then end of stream to resync
  task automatic finish_stream(input int noise);
    repeat (noise) push_beat(8'($urandom), 1'b0, 1'b0);
    push_beat(8'($urandom), 1'b1, 1'b1);
  endtask

  // mostly short payloads, now and then a longer one
  function automatic int pick_len();
    int hi;
    hi = ($urandom_range(0, 9) == 0) ? 80 : 12;
    if (int'(sb.max_pay) < hi) hi = int'(sb.max_pay);
    return $urandom_range(1, hi);
  endfunction

  task automatic random_setup();
    logic [31:0] mg;
    logic [15:0] vr;
    logic [23:0] mx;
    settle();
    case ($urandom_range(0, 2))
      0: mg = 32'h0000_0000;
      1: mg = 32'hFFFF_FFFF;
      default: mg = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: vr = 16'h0000;
      1: vr = 16'hFFFF;
      2: vr = 16'h0001;
      default: vr = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: mx = 24'd0;
      1, 2: mx = 24'd1;
      3, 4: mx = 24'd65536;
      5: mx = 24'hFF_FFFF;
      default: mx = 24'($urandom_range(1, 40));
    endcase
    write_reg(CFG_MAGIC, mg);
    write_reg(CFG_VERSION, {16'd0, vr});
    write_reg(CFG_MAX_PAY, {8'd0, mx});
  endtask

  initial begin
    int recs;
    int k;
    int ln;
    logic [31:0] bad_len;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MAGIC;
    cfg_data  = '0;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on reset registers: magic 0, version 1, max 65536
    push_beat(8'hA5, 1'b1, 1'b1);                            // end of stream at boundary: silent
    send_record(0, 1, 1, 1, 8'h00, -1, 1'b0);                // back-to-back ok records
    send_record(0, 1, 3, 3, 8'hFF, -1, 1'b0);
    send_record(0, 1, 2, 2, -1, -1, 1'b1);                   // crc mismatch
    finish_stream(3);
    send_record(0, 1, 0, 0, -1, -1, 1'b0);                   // zero length
    finish_stream(2);
    send_record(0, 1, 32'd65537, 0, -1, -1, 1'b0);           // just above max
    finish_stream(0);
    send_record(0, 1, 32'hFFFF_FFFF, 0, -1, -1, 1'b0);
    finish_stream(1);
    send_record(1, 1, 4, 0, -1, -1, 1'b0);                   // bad magic
    finish_stream(2);
    send_record(32'h8000_0000, 0, 0, 0, -1, -1, 1'b0);       // magic wins over version and length
    finish_stream(1);
    send_record(0, 16'hFFFF, 0, 0, -1, -1, 1'b0);            // version wins over length
    finish_stream(1);
    send_record(0, 1, 4, 4, -1, 3, 1'b0);                    // truncated header
    send_record(5, 1, 4, 4, -1, 5, 1'b0);                    // truncated after bad magic
    send_record(0, 2, 4, 4, -1, 8, 1'b0);                    // truncated after bad version
    send_record(0, 1, 4, 4, -1, 10, 1'b0);                   // eos right after header
    send_record(0, 1, 4, 4, -1, 12, 1'b0);                   // eos mid payload
    send_record(0, 1, 4, 4, -1, 14, 1'b0);                   // eos right after payload
    send_record(0, 1, 4, 4, -1, 16, 1'b0);                   // eos mid crc
    send_record(0, 1, 32'd65536, 4, -1, 12, 1'b0);           // length equal to max passes

    // all-ones magic and version, max of one
    settle();
    write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
    write_reg(CFG_VERSION, 32'h0000_FFFF);
    write_reg(CFG_MAX_PAY, 32'd1);
    send_record(32'hFFFF_FFFF, 16'hFFFF, 1, 1, -1, -1, 1'b0);
    send_record(32'hFFFF_FFFF, 16'hFFFF, 2, 0, -1, -1, 1'b0);
    finish_stream(1);

    // max of zero rejects every length
    settle();
    write_reg(CFG_MAX_PAY, 32'd0);
    send_record(32'hFFFF_FFFF, 16'hFFFF, 1, 0, -1, -1, 1'b0);
    finish_stream(0);

    // largest max, version zero
    settle();
    write_reg(CFG_MAGIC, 32'h5A5A_C3C3);
    write_reg(CFG_VERSION, 32'd0);
    write_reg(CFG_MAX_PAY, 32'h00FF_FFFF);
    send_record(32'h5A5A_C3C3, 0, 32'h00FF_FFFF, 3, -1, 13, 1'b0);
    send_record(32'h5A5A_C3C3, 0, 32'h0100_0000, 0, -1, -1, 1'b0);
    finish_stream(2);

    // random part: mostly good records, the rest broken or noise
    recs = 0;
    while (beats_sent < 1650) begin
      if (recs % 40 == 39) begin
        if ($urandom_range(0, 2) != 0) random_setup();
        else settle();
        calm = ($urandom_range(0, 3) == 0);
      end
      k = $urandom_range(0, 99);
      if (sb.max_pay == 0 && k < 72) k = 80;
      if (k < 60) begin
        ln = pick_len();
        send_record(sb.magic, sb.version, ln, ln, -1, -1, 1'b0);
      end else if (k < 67) begin
        ln = pick_len();
        send_record(sb.magic, sb.version, ln, ln, -1, -1, 1'b1);
        finish_stream($urandom_range(0, 4));
      end else if (k < 72) begin
        ln = pick_len();
        send_record(sb.magic, sb.version, ln, ln, -1, $urandom_range(1, ln + 13), 1'b0);
      end else if (k < 80) begin
        case ($urandom_range(0, 2))
          0: send_record(sb.magic ^ (32'd1 << $urandom_range(0, 31)), sb.version,
                         $urandom_range(1, 8), 0, -1, -1, 1'b0);
          1: send_record(sb.magic, sb.version ^ (16'd1 << $urandom_range(0, 15)),
                         $urandom_range(1, 8), 0, -1, -1, 1'b0);
          default: send_record(~sb.magic, ~sb.version, 0, 0, -1, -1, 1'b0);
        endcase
        finish_stream($urandom_range(0, 4));
      end else if (k < 88) begin
        case ($urandom_range(0, 2))
          0: bad_len = 32'd0;
          1: bad_len = {8'd0, sb.max_pay} + 32'($urandom_range(1, 4));
          default: bad_len = 32'hFFFF_FFFF;
        endcase
        send_record(sb.magic, sb.version, bad_len, 0, -1, -1, 1'b0);
        finish_stream($urandom_range(0, 4));
      end else if (k < 92) begin
        // truncated header, possibly after a bad field
        send_record(($urandom_range(0, 1) != 0) ? sb.magic : 32'($urandom),
                    sb.version, 4, 0, -1, $urandom_range(1, 9), 1'b0);
      end else if (k < 96) begin
        push_beat(8'($urandom), 1'b1, 1'b1);
      end else begin
        // raw noise parsed as a header
        repeat ($urandom_range(1, 14)) push_beat(8'($urandom), 1'b0, 1'b1);
        finish_stream(0);
      end
      recs++;
    end

    settle();
    if (sb.pending() != 0) sb.flag_leftover();
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
